FILE: rtl/core/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types, constants and power-of-ten tables for the decimal rescale and
// compare block.
// ----------------------------------------------------------------------------
package drc_pkg;

	localparam int MAX_SCALE  = 38;
	localparam int DEC_DIGITS = 38;
	localparam int W          = 128;
	localparam int SCALE_W    = 6;
	localparam int DIV_STEPS  = 128;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = 2;
	localparam int IN_DATA_W  = 272;
	localparam int OUT_DATA_W = 136;

	localparam logic [1:0] KIND_MUL = 2'd0;
	localparam logic [1:0] KIND_DIV = 2'd1;
	localparam logic [1:0] KIND_CMP = 2'd2;
	localparam logic [1:0] KIND_FIX = 2'd3;

	localparam logic [1:0] ORD_LESS    = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;
	localparam logic [1:0] ORD_NONE    = 2'd3;

	typedef logic [W-1:0] w128_t;
	typedef logic [MAX_SCALE:0][W-1:0] tab_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               neg;
		logic               swap;
		logic               fix_loss;
		logic [1:0]         fix_order;
		logic [SCALE_W-1:0] cnt;
		w128_t              rem;
		w128_t              acc;
		w128_t              opd;
	} item_t;

	function automatic tab_t pow10_tab();
		tab_t  t;
		w128_t p;
		p = w128_t'(1);
		for (int i = 0; i <= MAX_SCALE; i++) begin
			t[i] = p;
			p = (p << 3) + (p << 1);
		end
		return t;
	endfunction

	function automatic tab_t lim_tab(input logic negate);
		tab_t  t;
		w128_t p;
		w128_t l;
		for (int i = 0; i <= MAX_SCALE; i++) begin
			p = w128_t'(1);
			for (int j = 0; j < DEC_DIGITS - i; j++) begin
				p = (p << 3) + (p << 1);
			end
			l = p - w128_t'(1);
			t[i] = negate ? (w128_t'(0) - l) : l;
		end
		return t;
	endfunction

	localparam tab_t POW10   = pow10_tab();
	localparam tab_t LIM_POS = lim_tab(1'b0);
	localparam tab_t LIM_NEG = lim_tab(1'b1);

	function automatic logic [SCALE_W-1:0] sat_scale(input logic [SCALE_W-1:0] s);
		return (s > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : s;
	endfunction

endpackage

FILE: rtl/core/drc_front.sv
// ----------------------------------------------------------------------------
// drc_front
// Accepts input beats, saturates the scales and classifies each item into a
// scale-up, divide, compare or fixed-answer job for the back end.
// ----------------------------------------------------------------------------
module drc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// a_high, a_low, b_high, b_low, scale_a, scale_b, zero fill
	input  logic [drc_pkg::IN_DATA_W-1:0]   s_tdata,
	// op
	input  logic                            s_tuser,
	output drc_pkg::item_t                  item,
	output logic                            push,
	input  logic                            full
);
	import drc_pkg::*;

	logic               v_s1, v_s2;
	logic               rdy_s1, rdy_s2;
	logic               op_s1;
	w128_t              a_s1, b_s1;
	logic [SCALE_W-1:0] sa_s1, sb_s1;
	item_t              item_s2, item_c;

	logic               eq, up, gt, ovf, xneg, direct;
	logic [SCALE_W-1:0] d;
	w128_t              x, y;

	assign rdy_s2   = !v_s2 || !full;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign push     = v_s2 && !full;
	assign item     = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy_s1) begin
			op_s1 <= s_tuser;
			a_s1  <= {s_tdata[63:0], s_tdata[127:64]};
			b_s1  <= {s_tdata[191:128], s_tdata[255:192]};
			sa_s1 <= sat_scale(s_tdata[261:256]);
			sb_s1 <= sat_scale(s_tdata[267:262]);
		end
		if (v_s1 && rdy_s2) item_s2 <= item_c;
	end

	always_comb begin
		eq     = (sa_s1 == sb_s1);
		up     = (sb_s1 > sa_s1);
		gt     = (sa_s1 > sb_s1);
		d      = gt ? (sa_s1 - sb_s1) : (sb_s1 - sa_s1);
		x      = (op_s1 && gt) ? b_s1 : a_s1;
		y      = gt ? a_s1 : b_s1;
		xneg   = x[W-1];
		ovf    = ($signed(x) > $signed(LIM_POS[d])) || ($signed(x) < $signed(LIM_NEG[d]));
		direct = eq || (a_s1 == '0) || (b_s1 == '0);

		item_c           = '0;
		item_c.kind      = KIND_MUL;
		item_c.acc       = a_s1;
		if (!op_s1) begin
			if (gt) begin
				item_c.kind = KIND_DIV;
				item_c.neg  = a_s1[W-1];
				item_c.acc  = a_s1[W-1] ? (w128_t'(0) - a_s1) : a_s1;
				item_c.opd  = POW10[d];
			end else if (up) begin
				if (ovf) begin
					item_c.kind     = KIND_FIX;
					item_c.fix_loss = 1'b1;
					item_c.acc      = '0;
				end else begin
					item_c.cnt = d;
				end
			end
		end else begin
			item_c.kind = KIND_CMP;
			if (direct) begin
				item_c.opd = b_s1;
			end else if (a_s1[W-1] != b_s1[W-1]) begin
				item_c.kind      = KIND_FIX;
				item_c.fix_order = a_s1[W-1] ? ORD_LESS : ORD_GREATER;
			end else if (ovf) begin
				item_c.kind      = KIND_FIX;
				item_c.fix_order = (xneg ^ gt) ? ORD_LESS : ORD_GREATER;
			end else begin
				item_c.acc  = x;
				item_c.opd  = y;
				item_c.swap = gt;
				item_c.cnt  = d;
			end
		end
	end

endmodule

FILE: rtl/core/drc_queue.sv
// ----------------------------------------------------------------------------
// drc_queue
// Small first-in first-out buffer of classified items between the front end
// and the back end.
// ----------------------------------------------------------------------------
module drc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  drc_pkg::item_t push_item,
	input  logic           pop,
	output drc_pkg::item_t head,
	output logic           full,
	output logic           empty
);
	import drc_pkg::*;

	item_t         mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;

	assign full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_item;
	end

endmodule

FILE: rtl/core/drc_back.sv
// ----------------------------------------------------------------------------
// drc_back
// Execution pipeline: one restoring-division step per stage, a multiply by
// ten in each of the first stages, then result formatting into the output
// register.
// ----------------------------------------------------------------------------
module drc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  drc_pkg::item_t                 head,
	input  logic                           empty,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// value_high, value_low, data_loss, order, zero fill
	output logic [drc_pkg::OUT_DATA_W-1:0] m_tdata
);
	import drc_pkg::*;

	item_t st_q  [DIV_STEPS+1];
	item_t nxt   [DIV_STEPS+1];
	logic  vld_q [DIV_STEPS+1];
	logic  adv;
	logic  o_valid_q;
	logic [OUT_DATA_W-1:0] o_data_q;

	item_t      fin;
	w128_t      quo, val;
	logic       loss, c_gt, c_lt;
	logic [1:0] ord;

	assign adv      = !o_valid_q || m_tready;
	assign pop      = adv && !empty;
	assign m_tvalid = o_valid_q;
	assign m_tdata  = o_data_q;
	assign nxt[0]   = head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) st_q[0] <= nxt[0];
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		w128_t t;
		logic  ge;

		always_comb begin
			nxt[k] = st_q[k-1];
			t      = {st_q[k-1].rem[W-2:0], st_q[k-1].acc[W-1]};
			ge     = (t >= st_q[k-1].opd);
			if (st_q[k-1].kind == KIND_DIV) begin
				nxt[k].rem = ge ? (t - st_q[k-1].opd) : t;
				nxt[k].acc = {st_q[k-1].acc[W-2:0], ge};
			end else if ((k <= MAX_SCALE) && (st_q[k-1].cnt != '0)) begin
				nxt[k].acc = (st_q[k-1].acc << 3) + (st_q[k-1].acc << 1);
				nxt[k].cnt = st_q[k-1].cnt - 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv) begin
				vld_q[k] <= vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) st_q[k] <= nxt[k];
		end
	end

	always_comb begin
		fin  = st_q[DIV_STEPS];
		quo  = fin.neg ? (w128_t'(0) - fin.acc) : fin.acc;
		c_gt = $signed(fin.acc) > $signed(fin.opd);
		c_lt = $signed(fin.acc) < $signed(fin.opd);
		val  = '0;
		loss = 1'b0;
		ord  = ORD_LESS;
		unique case (fin.kind)
			KIND_MUL: begin
				val = fin.acc;
			end
			KIND_DIV: begin
				val  = quo;
				loss = (fin.rem != '0);
			end
			KIND_CMP: begin
				if (c_gt)      ord = fin.swap ? ORD_LESS : ORD_GREATER;
				else if (c_lt) ord = fin.swap ? ORD_GREATER : ORD_LESS;
				else           ord = ORD_EQUAL;
			end
			default: begin
				loss = fin.fix_loss;
				ord  = fin.fix_order;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (adv) begin
			o_valid_q <= vld_q[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) o_data_q <= {5'b0, ord, loss, val[63:0], val[127:64]};
	end

endmodule

FILE: rtl/core/decimal128_rescale_compare.sv
// ----------------------------------------------------------------------------
// decimal128_rescale_compare
// Signed 128-bit decimal rescale and cross-scale compare.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream: tuser carries the operation (rescale A or
// compare A with B), tdata carries both 128-bit operands and their scales.
// Each item produces one result beat on the m_ stream with the rescaled value,
// the data loss flag and the compare order.
// The block takes one beat per cycle while the receiver accepts results. Each
// input beat passes through the two front stages, the queue, the 128-stage
// restoring divider, which retires one quotient bit per stage, and the output
// register. Scaling up uses one multiply by ten per stage in the first stages
// of the same pipeline.
// Reset clears all valid flags; no result is pending afterward.
// When the receiver stalls, the output register holds its beat and the
// execution pipeline halts; the four-entry queue and the front stages keep
// taking beats until they fill, and then s_tready drops.
// ----------------------------------------------------------------------------
module decimal128_rescale_compare (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// a_high, a_low, b_high, b_low, scale_a, scale_b, zero fill
	input  logic [drc_pkg::IN_DATA_W-1:0]   s_tdata,
	// op
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// value_high, value_low, data_loss, order, zero fill
	output logic [drc_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import drc_pkg::*;

	item_t push_item, head;
	logic  push, pop, q_full, q_empty;

	drc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.item     (push_item),
		.push     (push),
		.full     (q_full)
	);

	drc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	drc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("queue read while empty");

	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[130:129] != ORD_NONE))
		else $error("invalid order code");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[130:129] != ORD_LESS)) |-> (m_tdata[128:0] == '0))
		else $error("compare result carries a value");
`endif

endmodule
